// ----- sv/vdpb_pkg.sv -----
// Package for the vertex welding block with periodic box folding.
// Holds the sequencer state type, register indexes and field widths.
// No dependencies.
`default_nettype none

package vdpb_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam int COORD_W   = 32;
    localparam int LEN_W     = 31;
    localparam int VIDX_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DAT_W  = 3 * COORD_W;
    localparam int OUT_DAT_W = 16;
    localparam int OUT_USR_W = 2;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int STEP_W    = 3;

    localparam logic [STEP_W-1:0] FOLD_LAST = 3'd5;

    localparam logic [LEN_W-1:0] BOX_RESET = 31'd65536;
    localparam logic [LEN_W-1:0] TOL_RESET = 31'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X    = 3'd0,
        REG_BOX_Y    = 3'd1,
        REG_BOX_Z    = 3'd2,
        REG_TOL      = 3'd3,
        REG_PERIODIC = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- sv/vertex_dedup_periodic_box.sv -----
// Vertex welding block: folds a Q16.16 vertex into a periodic box and looks
// it up in a table of unique vertices, appending it when nothing is close.
// Depends on vdpb_pkg.
//
// Usage: one vertex per input item on s_tdata (x, y, z from the low bits).
// One result per item on m_tdata (vertex index) and m_tuser (is_new in bit
// 0, table_overflow in bit 1). Registers are written through the cfg
// channel, which is always ready; write them only while the block is idle.
// Timing: s_tready is high only while the sequencer is idle. After an item
// is accepted, periodic mode folds the three axes in turn through one
// shared adder. The search then reads one stored entry per cycle from a
// single-port table with a registered read, and the finish state loads the
// result once the result register is free. The result register lets the
// next item be accepted and searched while a result waits; a stalled
// receiver holds that next item in the finish state, so no further item
// is accepted until the waiting result is taken.
// Reset empties the table (count to zero) and restores the register defaults;
// it needs no clearing pass.
`default_nettype none

module vertex_dedup_periodic_box
    import vdpb_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DAT_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_DAT_W-1:0]      m_tdata,   // vertex_index, zero pad
    output logic [OUT_USR_W-1:0]      m_tuser,   // is_new, table_overflow
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [LEN_W-1:0]   box_reg [AXES];
    logic [LEN_W-1:0]   tol_reg;
    logic               periodic_reg;

    logic [COORD_W-1:0] work_reg  [AXES];
    logic [COORD_W-1:0] work_next [AXES];

    logic [STEP_W-1:0]  fold_step_reg, fold_step_next;
    logic [CNT_W-1:0]   search_idx_reg, search_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic [CNT_W-1:0]   entry_count_reg, entry_count_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [VIDX_W-1:0]  vidx_reg, vidx_next;
    logic               is_new_reg, is_new_next;
    logic               ovf_reg, ovf_next;
    logic               out_load;

    logic [3*COORD_W-1:0] mem [TABLE_DEPTH];
    logic [3*COORD_W-1:0] rd_data_reg;
    logic                 rd_en;
    logic                 wr_en;

    logic [AXIS_W-1:0]  fold_axis;
    logic               fold_sub;
    logic [COORD_W:0]   fold_a;
    logic [COORD_W:0]   fold_b;
    logic [COORD_W:0]   fold_sum;
    logic               fold_apply;

    logic [AXES-1:0]    axis_close;
    logic               entry_match;
    logic               table_full;

    // Shared fold adder: even steps add the box to a negative coordinate,
    // odd steps subtract it when the coordinate lies above the box.
    always_comb
    begin
        fold_axis  = fold_step_reg[2:1];
        fold_sub   = fold_step_reg[0];
        fold_a     = {work_reg[fold_axis][COORD_W-1], work_reg[fold_axis]};
        fold_b     = {2'b00, box_reg[fold_axis]};
        fold_sum   = fold_sub ? (fold_a - fold_b) : (fold_a + fold_b);
        fold_apply = fold_sub ? (!fold_sum[COORD_W] && (fold_sum != '0))
                              : work_reg[fold_axis][COORD_W-1];
    end

    // Compare unit: one stored entry against the working vertex per cycle.
    always_comb
    begin
        logic [COORD_W-1:0] stored;
        logic [COORD_W:0]   diff;
        logic [COORD_W:0]   mag;
        for (int a = 0; a < AXES; a++)
        begin
            stored        = rd_data_reg[a*COORD_W +: COORD_W];
            diff          = {stored[COORD_W-1], stored}
                          - {work_reg[a][COORD_W-1], work_reg[a]};
            mag           = diff[COORD_W] ? (~diff + 1'b1) : diff;
            axis_close[a] = mag < {2'b00, tol_reg};
        end
        entry_match = &axis_close;
    end

    assign table_full = (entry_count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        state_next       = state_reg;
        work_next        = work_reg;
        fold_step_next   = fold_step_reg;
        search_idx_next  = search_idx_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        entry_count_next = entry_count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        vidx_next        = vidx_reg;
        is_new_next      = is_new_reg;
        ovf_next         = ovf_reg;
        out_load         = 1'b0;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        s_tready         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    for (int a = 0; a < AXES; a++)
                    begin
                        work_next[a] = s_tdata[a*COORD_W +: COORD_W];
                    end
                    fold_step_next  = '0;
                    search_idx_next = '0;
                    state_next      = periodic_reg ? ST_FOLD : ST_SEARCH;
                end
            end
            ST_FOLD:
            begin
                if (fold_apply)
                begin
                    work_next[fold_axis] = fold_sum[COORD_W-1:0];
                end
                if (fold_step_reg == FOLD_LAST)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    fold_step_next = fold_step_reg + 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (chk_vld_reg && entry_match)
                begin
                    found_next     = 1'b1;
                    found_idx_next = chk_idx_reg;
                    state_next     = ST_FINISH;
                end
                else if (search_idx_reg < entry_count_reg)
                begin
                    rd_en           = 1'b1;
                    chk_vld_next    = 1'b1;
                    chk_idx_next    = search_idx_reg[IDX_W-1:0];
                    search_idx_next = search_idx_reg + 1'b1;
                end
                else if (!chk_vld_reg)
                begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (found_reg)
                    begin
                        vidx_next   = VIDX_W'(found_idx_reg);
                        is_new_next = 1'b0;
                        ovf_next    = 1'b0;
                    end
                    else if (table_full)
                    begin
                        vidx_next   = '0;
                        is_new_next = 1'b0;
                        ovf_next    = 1'b1;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        vidx_next        = VIDX_W'(entry_count_reg[IDX_W-1:0]);
                        is_new_next      = 1'b1;
                        ovf_next         = 1'b0;
                        entry_count_next = entry_count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fold_step_reg   <= '0;
            search_idx_reg  <= '0;
            chk_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            entry_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                box_reg[a] <= BOX_RESET;
            end
            tol_reg         <= TOL_RESET;
            periodic_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fold_step_reg   <= fold_step_next;
            search_idx_reg  <= search_idx_next;
            chk_vld_reg     <= chk_vld_next;
            found_reg       <= found_next;
            entry_count_reg <= entry_count_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BOX_X, REG_BOX_Y, REG_BOX_Z:
                    begin
                        box_reg[cfg_index[AXIS_W-1:0]] <= cfg_data[LEN_W-1:0];
                    end
                    REG_TOL:
                    begin
                        tol_reg <= cfg_data[LEN_W-1:0];
                    end
                    REG_PERIODIC:
                    begin
                        periodic_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        chk_idx_reg   <= chk_idx_next;
        found_idx_reg <= found_idx_next;
        vidx_reg      <= vidx_next;
        is_new_reg    <= is_new_next;
        ovf_reg       <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[entry_count_reg[IDX_W-1:0]] <= {work_reg[2], work_reg[1], work_reg[0]};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[search_idx_reg[IDX_W-1:0]];
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_DAT_W'(vidx_reg);
    assign m_tuser   = {ovf_reg, is_new_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flagged both new and overflow");

    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_new_next) |=>
            (entry_count_reg == $past(entry_count_reg) + CNT_W'(1)))
        else $error("new entry did not advance the count");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> table_full)
        else $error("overflow reported while table not full");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for vertex_dedup_periodic_box: drives vertex items, predicts the
// welded index, new and overflow flags, and checks every result in order.
// Depends on vdpb_pkg and the vertex_dedup_periodic_box RTL.

module tb;
    import vdpb_pkg::*;

    localparam int WELD_DEPTH = DEF_TABLE_DEPTH;
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 92;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFFFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h80000000;
    localparam logic [CFG_DAT_W-1:0] LEN_MAX = 32'h7FFFFFFF;
    localparam int REG_SPARE_LO = 5;
    localparam int REG_SPARE_HI = 7;

    typedef struct packed {
        logic [VIDX_W-1:0] index;
        logic              is_new;
        logic              overflow;
    } weld_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DAT_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DAT_W-1:0]  m_tdata;
    logic [OUT_USR_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    logic [LEN_W-1:0]          box_len [AXES];
    logic [LEN_W-1:0]          weld_tol;
    logic                      wrap_on;
    logic signed [COORD_W-1:0] weld_tab [WELD_DEPTH][AXES];
    int                        weld_count;

    weld_res_t           weld_expect [$];
    logic [IN_DAT_W-1:0] vertex_pool [$];
    int                  err_count = 0;
    int                  quiet_cycles = 0;
    int                  rx_hold = 0;
    int                  rx_gap = 0;
    bit                  tx_idle_on = 1'b1;
    bit                  rx_idle_on = 1'b1;

    vertex_dedup_periodic_box #(
        .TABLE_DEPTH(WELD_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        if (roll < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic longint fold_coord(input longint c, input longint len);
        if (c < 0)
        begin
            c += len;
        end
        if (c > len)
        begin
            c -= len;
        end
        return c;
    endfunction

    function automatic bit axis_near(input logic signed [COORD_W-1:0] held, input longint c);
        longint d;
        d = longint'(held) - c;
        if (d < 0)
        begin
            d = -d;
        end
        return d < longint'(weld_tol);
    endfunction

    function automatic weld_res_t weld_vertex(input logic [IN_DAT_W-1:0] raw);
        longint    c [AXES];
        weld_res_t r;
        bit        hit;
        r = '0;
        for (int a = 0; a < AXES; a++)
        begin
            c[a] = longint'($signed(raw[a*COORD_W +: COORD_W]));
            if (wrap_on)
            begin
                c[a] = fold_coord(c[a], longint'(box_len[a]));
            end
        end
        for (int i = 0; i < weld_count; i++)
        begin
            hit = 1'b1;
            for (int a = 0; a < AXES; a++)
            begin
                if (!axis_near(weld_tab[i][a], c[a]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                r.index = VIDX_W'(i);
                return r;
            end
        end
        if (weld_count >= WELD_DEPTH)
        begin
            r.overflow = 1'b1;
            return r;
        end
        for (int a = 0; a < AXES; a++)
        begin
            weld_tab[weld_count][a] = COORD_W'(c[a]);
        end
        r.index = VIDX_W'(weld_count);
        r.is_new = 1'b1;
        weld_count++;
        return r;
    endfunction

    function automatic void report_fault(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_vertex(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                               input logic [COORD_W-1:0] cz);
        int                  gap;
        logic [IN_DAT_W-1:0] vtx;
        weld_res_t           want;
        gap = pick_gap(tx_idle_on);
        vtx = {cz, cy, cx};
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= vtx;
        do @(posedge clk); while (!s_tready);
        want = weld_vertex(vtx);
        weld_expect = {weld_expect, want};
        vertex_pool = {vertex_pool, vtx};
        if (vertex_pool.size() > 64)
        begin
            void'(vertex_pool.pop_front());
        end
    endtask

    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (weld_expect.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BOX_X:    box_len[0] = val[LEN_W-1:0];
            REG_BOX_Y:    box_len[1] = val[LEN_W-1:0];
            REG_BOX_Z:    box_len[2] = val[LEN_W-1:0];
            REG_TOL:      weld_tol = val[LEN_W-1:0];
            REG_PERIODIC: wrap_on = val[0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_weld_config(input logic [CFG_DAT_W-1:0] bx, input logic [CFG_DAT_W-1:0] by,
                                   input logic [CFG_DAT_W-1:0] bz, input logic [CFG_DAT_W-1:0] tol,
                                   input logic [CFG_DAT_W-1:0] wrap);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_TOL, tol);
        write_reg(REG_PERIODIC, wrap);
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_box_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return '0;
        end
        if (roll == 1)
        begin
            return '1;
        end
        if (roll < 4)
        begin
            return $urandom();
        end
        return $urandom_range(1, 32'h0010_0000);
    endfunction

    task automatic send_random_vertex();
        logic [COORD_W-1:0] v [AXES];
        logic [COORD_W-1:0] noise;
        int                 kind;
        int                 pick;
        int                 span;
        int                 axis;
        kind = $urandom_range(0, 99);
        if (kind < 60 && vertex_pool.size() > 0)
        begin
            // A jittered copy of a recent vertex straddles a tolerance of at most 65536.
            pick = $urandom_range(0, vertex_pool.size() - 1);
            span = (weld_tol > 31'd65536) ? 65536 : int'(weld_tol);
            for (int a = 0; a < AXES; a++)
            begin
                v[a] = vertex_pool[pick][a*COORD_W +: COORD_W]
                     + COORD_W'(int'($urandom_range(0, 2 * span + 1)) - span);
            end
            if (wrap_on && $urandom_range(0, 2) == 0)
            begin
                axis = $urandom_range(0, AXES - 1);
                if ($urandom_range(0, 1) == 1)
                begin
                    v[axis] = v[axis] + COORD_W'(box_len[axis]);
                end
                else
                begin
                    v[axis] = v[axis] - COORD_W'(box_len[axis]);
                end
            end
        end
        else if (kind < 80)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                noise = $urandom();
                v[a] = {{13{noise[19]}}, noise[18:0]};
            end
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
            begin
                v[a] = $urandom();
            end
        end
        send_vertex(v[0], v[1], v[2]);
    endtask

    task automatic test_default_welding();
        send_vertex('0, '0, '0);
        send_vertex(32'sd15, -32'sd15, 32'sd15);
        send_vertex(32'sd16, '0, '0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MIN);
        send_vertex('1, '1, '1);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX);
    endtask

    task automatic test_spare_registers();
        settle_block();
        for (int r = REG_SPARE_LO; r <= REG_SPARE_HI; r++)
        begin
            write_reg(CFG_IDX_W'(r), '1);
        end
        send_vertex('0, '0, 32'sd16);
    endtask

    task automatic test_box_folding();
        settle_block();
        set_weld_config(32'd131072, '0, LEN_MAX, 32'd16, 32'd1);
        send_vertex(-32'sd65536, '0, COORD_MIN);
        send_vertex(32'd131072, 32'd5, '0);
        send_vertex(32'd131073, COORD_MIN, 32'd3);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
        send_vertex(-32'sd65530, 32'sd4, COORD_MIN);
        settle_block();
        set_weld_config('1, '1, '1, 32'd16, '1);
        send_vertex(COORD_MIN, -32'sd7, COORD_MAX);
    endtask

    task automatic test_tolerance_extremes();
        settle_block();
        set_weld_config(BOX_RESET, BOX_RESET, BOX_RESET, '1, '0);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
        send_vertex(32'h4000_0000, 32'hC000_0000, '0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
        settle_block();
        write_reg(REG_TOL, '0);
        send_vertex('0, '0, '0);
        send_vertex('0, '0, '0);
    endtask

    task automatic test_random_welding();
        logic [CFG_DAT_W-1:0] tol;
        int                   roll;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_block();
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                tol = $urandom();
            end
            else if (roll == 1)
            begin
                tol = 32'd1;
            end
            else
            begin
                tol = $urandom_range(2, 4096);
            end
            set_weld_config(pick_box_len(), pick_box_len(), pick_box_len(), tol,
                            (p % 2 == 0) ? 32'd1 : 32'd0);
            tx_idle_on = (p % 3 != 1) && (p != RANDOM_PHASES - 1);
            rx_idle_on = (p % 3 != 2) && (p != RANDOM_PHASES - 1);
            repeat (PHASE_ITEMS) send_random_vertex();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        settle_block();
        tx_idle_on = 1'b0;
        rx_hold = 400;
        repeat (10) send_random_vertex();
        // The sender pauses here until every result has come out.
        settle_block();
        tx_idle_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap--;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_gap = pick_gap(rx_idle_on);
        end
    end

    always @(posedge clk)
    begin
        weld_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (weld_expect.size() == 0)
            begin
                report_fault($sformatf("unexpected result: index %0d new %0b overflow %0b",
                                       m_tdata, m_tuser[0], m_tuser[1]));
            end
            else
            begin
                want = weld_expect.pop_front();
                if (m_tdata !== {{(OUT_DAT_W - VIDX_W){1'b0}}, want.index} ||
                    m_tuser[0] !== want.is_new || m_tuser[1] !== want.overflow)
                begin
                    report_fault($sformatf({"result mismatch: expected index %0d new %0b ",
                                            "overflow %0b, got index %0d new %0b overflow %0b"},
                                           want.index, want.is_new, want.overflow,
                                           m_tdata, m_tuser[0], m_tuser[1]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        box_len = '{BOX_RESET, BOX_RESET, BOX_RESET};
        weld_tol = TOL_RESET;
        wrap_on = 1'b0;
        weld_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_welding();
        test_spare_registers();
        test_box_folding();
        test_tolerance_extremes();
        test_random_welding();
        test_output_backpressure();

        settle_block();
        repeat (WELD_DEPTH + 16) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
